>>> rtl/spsc_pkg.sv
package spsc_pkg;

    localparam int DEPTH  = 256;
    localparam int WIDTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRC_RD,
        ST_TOP_RD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WIDTH-1:0]  wdata;
    } t_ram_req;

endpackage

>>> rtl/stack_pop_sequence_check.sv
// Stack pop-order checker. Load a push order with command 0 beats, then stream a candidate
// pop order with command 1 beats; each pop beat yields one result on o_strobe, carrying the
// verdict so far and, on the beat marked last, the final verdict, after which a new run
// begins. A load beat is taken in the idle state without leaving it and yields no result.
// A pop beat passes through a check state, then a source read and a stack write for every
// source element pushed onto the internal stack, a top-of-stack read when a match leaves at
// least one entry below the top, and a finish state; a pop beat that arrives once the run
// has already failed goes straight to the finish state. The stack and source memories each
// have one port and a registered read, which sets this sequence of states. Over a run the
// pushes never exceed the loaded length. The result is on the ports in the first cycle that
// busy is low again and is held for that cycle only: the receiver must take it then.
module stack_pop_sequence_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [spsc_pkg::WIDTH-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_strobe,
    output logic                       o_valid_so_far,
    output logic                       o_final_res
);

    spsc_pkg::t_ram_req         src_req;
    spsc_pkg::t_ram_req         lifo_req;
    logic [spsc_pkg::WIDTH-1:0] src_rdata;
    logic [spsc_pkg::WIDTH-1:0] lifo_rdata;

    spsc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_src_req      (src_req),
        .i_src_rdata    (src_rdata),
        .o_lifo_req     (lifo_req),
        .i_lifo_rdata   (lifo_rdata),
        .o_strobe       (o_strobe),
        .o_valid_so_far (o_valid_so_far),
        .o_final_res    (o_final_res)
    );

    spsc_ram #(
        .DEPTH_P (spsc_pkg::DEPTH),
        .WIDTH_P (spsc_pkg::WIDTH)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_req.we),
        .i_addr  (src_req.addr),
        .i_wdata (src_req.wdata),
        .o_rdata (src_rdata)
    );

    spsc_ram #(
        .DEPTH_P (spsc_pkg::DEPTH),
        .WIDTH_P (spsc_pkg::WIDTH)
    ) u_lifo_ram (
        .i_clk   (i_clk),
        .i_we    (lifo_req.we),
        .i_addr  (lifo_req.addr),
        .i_wdata (lifo_req.wdata),
        .o_rdata (lifo_rdata)
    );

endmodule

>>> rtl/spsc_ram.sv
module spsc_ram #(
    parameter int DEPTH_P = 256,
    parameter int WIDTH_P = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH_P)-1:0] i_addr,
    input  logic [WIDTH_P-1:0]         i_wdata,
    output logic [WIDTH_P-1:0]         o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/spsc_ctrl.sv
module spsc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [spsc_pkg::WIDTH-1:0]     i_value,
    input  logic                           i_last,
    output spsc_pkg::t_ram_req             o_src_req,
    input  logic [spsc_pkg::WIDTH-1:0]     i_src_rdata,
    output spsc_pkg::t_ram_req             o_lifo_req,
    input  logic [spsc_pkg::WIDTH-1:0]     i_lifo_rdata,
    output logic                           o_strobe,
    output logic                           o_valid_so_far,
    output logic                           o_final_res
);

    localparam int CW = spsc_pkg::CNT_W;
    localparam int AW = spsc_pkg::ADDR_W;

    spsc_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_src_cnt, n_src_cnt;
    logic [CW-1:0]                r_src_nxt, n_src_nxt;
    logic [CW-1:0]                r_ptr, n_ptr;
    logic [CW-1:0]                r_pop_cnt, n_pop_cnt;
    logic                         r_failed, n_failed;
    logic [spsc_pkg::WIDTH-1:0]   r_top, n_top;
    logic [spsc_pkg::WIDTH-1:0]   r_val, n_val;
    logic                         r_last, n_last;
    logic                         r_strobe, n_strobe;
    logic                         r_ok, n_ok;
    logic                         r_fin, n_fin;
    logic                         fail_now;
    logic [CW-1:0]                ptr_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spsc_pkg::ST_IDLE;
            r_src_cnt <= '0;
            r_src_nxt <= '0;
            r_ptr     <= '0;
            r_pop_cnt <= '0;
            r_failed  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_src_cnt <= n_src_cnt;
            r_src_nxt <= n_src_nxt;
            r_ptr     <= n_ptr;
            r_pop_cnt <= n_pop_cnt;
            r_failed  <= n_failed;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_val  <= n_val;
        r_last <= n_last;
        r_ok   <= n_ok;
        r_fin  <= n_fin;
    end

    assign ptr_m2   = r_ptr - CW'(2);
    assign fail_now = r_failed | (r_last & (r_pop_cnt != r_src_cnt));

    always_comb begin
        n_state   = r_state;
        n_src_cnt = r_src_cnt;
        n_src_nxt = r_src_nxt;
        n_ptr     = r_ptr;
        n_pop_cnt = r_pop_cnt;
        n_failed  = r_failed;
        n_top     = r_top;
        n_val     = r_val;
        n_last    = r_last;
        n_strobe  = 1'b0;
        n_ok      = r_ok;
        n_fin     = r_fin;

        o_src_req.we     = 1'b0;
        o_src_req.addr   = r_src_cnt[AW-1:0];
        o_src_req.wdata  = i_value;
        o_lifo_req.we    = 1'b0;
        o_lifo_req.addr  = r_ptr[AW-1:0];
        o_lifo_req.wdata = i_src_rdata;

        unique case (r_state)
            spsc_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_command == spsc_pkg::CMD_LOAD) begin
                        if (r_src_cnt < CW'(spsc_pkg::DEPTH)) begin
                            o_src_req.we = 1'b1;
                            n_src_cnt    = r_src_cnt + CW'(1);
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else begin
                        n_val  = i_value;
                        n_last = i_last;
                        if (r_pop_cnt <= CW'(spsc_pkg::DEPTH)) begin
                            n_pop_cnt = r_pop_cnt + CW'(1);
                        end
                        n_state = r_failed ? spsc_pkg::ST_FINISH : spsc_pkg::ST_CHECK;
                    end
                end
            end
            spsc_pkg::ST_CHECK: begin
                if ((r_ptr != '0) && (r_top == r_val)) begin
                    n_ptr = r_ptr - CW'(1);
                    if (r_ptr >= CW'(2)) begin
                        o_lifo_req.addr = ptr_m2[AW-1:0];
                        n_state         = spsc_pkg::ST_TOP_RD;
                    end else begin
                        n_state = spsc_pkg::ST_FINISH;
                    end
                end else if ((r_src_nxt >= r_src_cnt) ||
                             (r_ptr >= CW'(spsc_pkg::DEPTH))) begin
                    n_failed = 1'b1;
                    n_state  = spsc_pkg::ST_FINISH;
                end else begin
                    o_src_req.addr = r_src_nxt[AW-1:0];
                    n_state        = spsc_pkg::ST_SRC_RD;
                end
            end
            spsc_pkg::ST_SRC_RD: begin
                o_lifo_req.we = 1'b1;
                n_top         = i_src_rdata;
                n_ptr         = r_ptr + CW'(1);
                n_src_nxt     = r_src_nxt + CW'(1);
                n_state       = spsc_pkg::ST_CHECK;
            end
            spsc_pkg::ST_TOP_RD: begin
                n_top   = i_lifo_rdata;
                n_state = spsc_pkg::ST_FINISH;
            end
            spsc_pkg::ST_FINISH: begin
                n_strobe = 1'b1;
                n_ok     = ~fail_now;
                n_fin    = r_last;
                if (r_last) begin
                    n_src_cnt = '0;
                    n_src_nxt = '0;
                    n_ptr     = '0;
                    n_pop_cnt = '0;
                    n_failed  = 1'b0;
                end else begin
                    n_failed = fail_now;
                end
                n_state = spsc_pkg::ST_IDLE;
            end
            default: begin
                n_state = spsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != spsc_pkg::ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_valid_so_far = r_ok;
    assign o_final_res    = r_fin;

endmodule

>>> tb/pop_verdict_checker.sv
module pop_verdict_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_command,
    input  logic [spsc_pkg::WIDTH-1:0] i_value,
    input  logic                       i_last,
    input  logic                       o_strobe,
    input  logic                       o_valid_so_far,
    input  logic                       o_final_res,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_compared,
    output int                         o_runs,
    output int                         o_runs_passed
);
    import spsc_pkg::*;

    typedef struct packed {
        logic valid_so_far;
        logic final_res;
    } t_verdict;

    logic [WIDTH-1:0] src_mem [DEPTH];
    logic [WIDTH-1:0] stk_mem [DEPTH];
    int unsigned      src_len;
    int unsigned      src_ptr;
    int unsigned      stk_lvl;
    int unsigned      pop_seen;
    bit               run_failed;
    t_verdict         verdict_q [$];
    int               mismatches  = 0;
    int               compared    = 0;
    int               runs        = 0;
    int               runs_passed = 0;

    task automatic clear_run();
        src_len    = 0;
        src_ptr    = 0;
        stk_lvl    = 0;
        pop_seen   = 0;
        run_failed = 1'b0;
    endtask

    task automatic load_source(input logic [WIDTH-1:0] v);
        if (src_len < DEPTH) begin
            src_mem[src_len] = v;
            src_len++;
        end else begin
            run_failed = 1'b1;
        end
    endtask

    // push source elements until the top matches, then drop the top
    task automatic match_pop(input logic [WIDTH-1:0] v);
        bit done;
        done = 1'b0;
        while (!done) begin
            if (stk_lvl > 0 && stk_mem[stk_lvl-1] == v) begin
                stk_lvl--;
                done = 1'b1;
            end else if (src_ptr >= src_len || stk_lvl >= DEPTH) begin
                run_failed = 1'b1;
                done = 1'b1;
            end else begin
                stk_mem[stk_lvl] = src_mem[src_ptr];
                stk_lvl++;
                src_ptr++;
            end
        end
    endtask

    task automatic predict_pop_verdict(input logic [WIDTH-1:0] v, input logic lst);
        t_verdict want;
        if (pop_seen <= DEPTH)
            pop_seen++;
        if (!run_failed)
            match_pop(v);
        if (lst && pop_seen != src_len)
            run_failed = 1'b1;
        want.valid_so_far = !run_failed;
        want.final_res    = lst;
        verdict_q.push_back(want);
        if (lst) begin
            runs++;
            if (!run_failed)
                runs_passed++;
            clear_run();
        end
    endtask

    initial clear_run();

    always @(posedge i_clk) begin : sample
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            clear_run();
            verdict_q.delete();
        end else begin
            if (o_strobe) begin
                got.valid_so_far = o_valid_so_far;
                got.final_res    = o_final_res;
                compared++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no beat pending: expected none, actual %b",
                             $time, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.valid_so_far !== want.valid_so_far) begin
                        mismatches++;
                        $display("%0t: valid_so_far expected %b actual %b",
                                 $time, want.valid_so_far, got.valid_so_far);
                    end
                    if (got.final_res !== want.final_res) begin
                        mismatches++;
                        $display("%0t: final_res expected %b actual %b",
                                 $time, want.final_res, got.final_res);
                    end
                end
            end
            if (start && !busy) begin
                if (i_command == CMD_LOAD)
                    load_source(i_value);
                else
                    predict_pop_verdict(i_value, i_last);
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= verdict_q.size();
        o_compared    <= compared;
        o_runs        <= runs;
        o_runs_passed <= runs_passed;
    end

endmodule

>>> tb/tb.sv
module tb;
    import spsc_pkg::*;

    localparam int BEAT_TARGET = 1350;
    localparam int PHASE_BEATS = 150;
    localparam int TAIL_CYCLES = 50;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_SWAP,
        SHAPE_BITFLIP,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_LATE_LOAD
    } t_shape;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_command;
    logic [WIDTH-1:0] i_value;
    logic             i_last;
    logic             o_strobe;
    logic             o_valid_so_far;
    logic             o_final_res;

    int          mismatches;
    int          pending;
    int          compared;
    int          runs;
    int          runs_passed;
    int          beats     = 0;
    int          loads     = 0;
    int          checks    = 0;
    int          idle_pct  = 0;
    int          idle_plan [4] = '{0, 49, 17, 0};
    int unsigned cycle_cnt = 0;

    stack_pop_sequence_check u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_valid_so_far (o_valid_so_far),
        .o_final_res    (o_final_res)
    );

    pop_verdict_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_valid_so_far (o_valid_so_far),
        .o_final_res    (o_final_res),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_compared     (compared),
        .o_runs         (runs),
        .o_runs_passed  (runs_passed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_cnt, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic drive_beat(input logic cmd, input logic [WIDTH-1:0] val, input logic lst);
        int gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        i_last    <= lst;
        do @(posedge i_clk); while (busy);
        beats++;
        if (cmd == CMD_LOAD)
            loads++;
        else
            checks++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [WIDTH-1:0] pick_value(input bit dup_mode);
        logic [WIDTH-1:0] v;
        v = WIDTH'($urandom);
        if (dup_mode) begin
            case ($urandom_range(3))
                0:       v = '0;
                1:       v = '1;
                default: v = WIDTH'($urandom_range(3));
            endcase
        end
        return v;
    endfunction

    // build a push order, derive a pop order from a random stack walk, then spoil it
    task automatic play_run(input int n, input t_shape shape, input bit dup_mode);
        logic [WIDTH-1:0] push_q [$];
        logic [WIDTH-1:0] pop_q  [$];
        logic [WIDTH-1:0] stk    [$];
        logic [WIDTH-1:0] tmp;
        int               i;
        int               a;
        int               b;
        int               mid;
        int               n_load;
        for (i = 0; i < n; i++)
            push_q.push_back(pick_value(dup_mode));
        i = 0;
        while (pop_q.size() < n) begin
            if (i < n && (stk.size() == 0 || $urandom_range(1) == 1)) begin
                stk.push_back(push_q[i]);
                i++;
            end else begin
                pop_q.push_back(stk.pop_back());
            end
        end
        case (shape)
            SHAPE_SWAP: begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                tmp = pop_q[a];
                pop_q[a] = pop_q[b];
                pop_q[b] = tmp;
            end
            SHAPE_BITFLIP: begin
                a = $urandom_range(n - 1);
                b = $urandom_range(WIDTH - 1);
                tmp = pop_q[a];
                tmp[b] = ~tmp[b];
                pop_q[a] = tmp;
            end
            SHAPE_SHORT: begin
                if (n > 1)
                    tmp = pop_q.pop_back();
            end
            SHAPE_LONG: pop_q.push_back(pick_value(dup_mode));
            default: ;
        endcase
        n_load = (shape == SHAPE_LATE_LOAD) ? n - 1 : n;
        mid    = (shape == SHAPE_LATE_LOAD) ? $urandom_range(pop_q.size() - 1) : -1;
        for (i = 0; i < n_load; i++)
            drive_beat(CMD_LOAD, push_q[i], $urandom_range(3) == 0);
        for (i = 0; i < pop_q.size(); i++) begin
            if (i == mid)
                drive_beat(CMD_LOAD, push_q[n-1], $urandom_range(3) == 0);
            drive_beat(CMD_CHECK, pop_q[i], i == pop_q.size() - 1);
        end
    endtask

    initial begin : stimulus
        bit     deep_full;
        bit     deep_over;
        int     n;
        int     k;
        t_shape shape;
        deep_full = 1'b0;
        deep_over = 1'b0;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_command <= CMD_LOAD;
        i_value   <= '0;
        i_last    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop against an empty source
        drive_beat(CMD_CHECK, 16'h0000, 1'b1);
        // last flag on a load, extreme values
        drive_beat(CMD_LOAD,  16'hFFFF, 1'b1);
        drive_beat(CMD_LOAD,  16'h0000, 1'b0);
        drive_beat(CMD_CHECK, 16'h0000, 1'b0);
        drive_beat(CMD_CHECK, 16'hFFFF, 1'b1);
        // impossible order, then a pop after failure
        drive_beat(CMD_LOAD,  16'h1234, 1'b0);
        drive_beat(CMD_LOAD,  16'h8001, 1'b0);
        drive_beat(CMD_LOAD,  16'h7FFE, 1'b0);
        drive_beat(CMD_CHECK, 16'h7FFE, 1'b0);
        drive_beat(CMD_CHECK, 16'h1234, 1'b0);
        drive_beat(CMD_CHECK, 16'h8001, 1'b1);
        // too few pops
        drive_beat(CMD_LOAD,  16'h0001, 1'b0);
        drive_beat(CMD_LOAD,  16'h0002, 1'b0);
        drive_beat(CMD_CHECK, 16'h0001, 1'b1);
        // load while checking
        drive_beat(CMD_LOAD,  16'h0005, 1'b0);
        drive_beat(CMD_CHECK, 16'h0005, 1'b0);
        drive_beat(CMD_LOAD,  16'h0006, 1'b0);
        drive_beat(CMD_CHECK, 16'h0006, 1'b1);
        // duplicates
        drive_beat(CMD_LOAD,  16'h0007, 1'b0);
        drive_beat(CMD_LOAD,  16'h0007, 1'b0);
        drive_beat(CMD_CHECK, 16'h0007, 1'b0);
        drive_beat(CMD_CHECK, 16'h0007, 1'b1);
        // too many pops
        drive_beat(CMD_LOAD,  16'h0009, 1'b0);
        drive_beat(CMD_CHECK, 16'h0009, 1'b0);
        drive_beat(CMD_CHECK, 16'h0009, 1'b1);
        wait_drained();

        while (beats < BEAT_TARGET) begin
            idle_pct = idle_plan[(beats / PHASE_BEATS) % 4];
            if (!deep_full && beats > 300) begin
                deep_full = 1'b1;
                play_run(DEPTH, SHAPE_CLEAN, 1'b0);
            end else if (!deep_over && beats > 700) begin
                // overflow the source, then drive pop_count into saturation
                deep_over = 1'b1;
                for (k = 0; k < DEPTH + 1; k++)
                    drive_beat(CMD_LOAD, pick_value(1'b0), 1'b0);
                for (k = 0; k < DEPTH + 4; k++)
                    drive_beat(CMD_CHECK, pick_value(1'b1), k == DEPTH + 3);
            end else if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    drive_beat(1'($urandom_range(1)), pick_value(1'($urandom_range(1))),
                               1'($urandom_range(1)));
            end else begin
                n = ($urandom_range(6) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                shape = ($urandom_range(9) < 5) ? SHAPE_CLEAN : t_shape'($urandom_range(1, 5));
                play_run(n, shape, $urandom_range(2) == 0);
            end
            if ($urandom_range(24) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Drove %0d beats (%0d loads, %0d pop checks), compared %0d results",
                 beats, loads, checks, compared);
        $display("%0d runs closed, %0d with an accepted pop order, %0d mismatches",
                 runs, runs_passed, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
